### design/bba_pkg.sv
// Shared constants, codes and types of the block bitmap allocator.
package bba_pkg;

   localparam int NUM_BLOCKS  = 64;
   // Block size must be a power of two: byte offsets split into index and offset bits.
   localparam int BLOCK_BYTES = 4096;
   localparam int TAG_BITS    = 16;

   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int IDX_W       = $clog2(NUM_BLOCKS);
   localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);

   localparam int FUNC_W   = 2;
   localparam int REQ_W    = 24;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 19;
   localparam int NEED_W   = REQ_W - BLOCK_SHIFT + 1;

   localparam logic [ADDR_W:0] POOL_BYTES = (ADDR_W + 1)'(NUM_BLOCKS) * (ADDR_W + 1)'(BLOCK_BYTES);

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_NO_SPACE,
      STATUS_BAD_ADDR
   } status_type;

   // Configuration register map
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_INDEX_W-1:0] REG_POOL_BASE = 1'b0;
   localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'h0060_0000;

   typedef struct packed {
      logic                strobe;
      status_type          status;
      logic [ADDR_W-1:0]   grant_address;
   } rsp_type;

endpackage

### design/block_bitmap_allocator_unit.sv
// Top level of the block bitmap allocator: APB registers, sequencer and tag RAM.
//
// First-fit allocator of contiguous fixed-size blocks. Start is taken when busy
// is low; the result shows on rsp_* for exactly one cycle with rsp_strobe high and
// cannot be held off. A query (or unused func code), a bad address, a free of a
// free block or an oversized request answers in the cycle after the transfer. An
// allocate keeps busy high while one pointer walks the free map a block per cycle
// up to the end of the run, then writes one tag per cycle into the tag RAM; when
// no run fits, the walk stops at the last block. A free keeps busy high while it
// walks the neighbors of the hit block, reading the tag RAM for one neighbor per
// cycle. The result shows in the same cycle that busy drops. The pool base must
// be written only while the block is idle.
module block_bitmap_allocator_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [bba_pkg::FUNC_W-1:0]       req_func,
   input  logic [bba_pkg::REQ_W-1:0]        req_request_bytes,
   input  logic [bba_pkg::ADDR_W-1:0]       req_release_address,
   output logic                             rsp_strobe,
   output logic [bba_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bba_pkg::ADDR_W-1:0]       rsp_grant_address,
   output logic [bba_pkg::USED_W-1:0]       rsp_bytes_in_use,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bba_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [bba_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   logic [bba_pkg::ADDR_W-1:0]   pool_base;
   bba_pkg::rsp_type             rsp;
   logic                         ram_wr_en;
   logic [bba_pkg::IDX_W-1:0]    ram_wr_addr;
   logic [bba_pkg::TAG_BITS-1:0] ram_wr_data;
   logic [bba_pkg::IDX_W-1:0]    ram_rd_addr;
   logic [bba_pkg::TAG_BITS-1:0] ram_rd_data;

   bba_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .pool_base (pool_base)
   );

   bba_ram #(
      .WIDTH (bba_pkg::TAG_BITS),
      .DEPTH (bba_pkg::NUM_BLOCKS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bba_engine u_engine (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .req_func            (req_func),
      .req_request_bytes   (req_request_bytes),
      .req_release_address (req_release_address),
      .pool_base           (pool_base),
      .busy                (busy),
      .rsp                 (rsp),
      .bytes_in_use        (rsp_bytes_in_use),
      .ram_wr_en           (ram_wr_en),
      .ram_wr_addr         (ram_wr_addr),
      .ram_wr_data         (ram_wr_data),
      .ram_rd_addr         (ram_rd_addr),
      .ram_rd_data         (ram_rd_data)
   );

   assign rsp_strobe        = rsp.strobe;
   assign rsp_status        = rsp.status;
   assign rsp_grant_address = rsp.grant_address;

endmodule

### design/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bba_csr.sv
// APB configuration register file: pool base address.
module bba_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bba_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [bba_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic [bba_pkg::ADDR_W-1:0]       pool_base
);

   logic [bba_pkg::ADDR_W-1:0]      pool_base_ff;
   logic [bba_pkg::ADDR_W-1:0]      pool_base_in;
   logic [bba_pkg::CSR_INDEX_W-1:0] reg_index;
   logic                            wr_transfer;

   assign reg_index   = paddr[bba_pkg::CSR_ADDR_W-1:2];
   assign wr_transfer = psel && penable && pwrite;
   assign pready      = 1'b1;

   always_comb begin
      pool_base_in = pool_base_ff;
      prdata       = '0;
      unique case (reg_index)
         bba_pkg::REG_POOL_BASE: begin
            prdata = bba_pkg::CSR_DATA_W'(pool_base_ff);
            if (wr_transfer) begin
               pool_base_in = bba_pkg::ADDR_W'(pwdata);
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= bba_pkg::POOL_BASE_RESET;
      end else begin
         pool_base_ff <= pool_base_in;
      end
   end

   assign pool_base = pool_base_ff;

endmodule

### design/bba_engine.sv
// Allocation sequencer: free-map scan, run marking and tag-matched release walk.
module bba_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bba_pkg::FUNC_W-1:0]    req_func,
   input  logic [bba_pkg::REQ_W-1:0]     req_request_bytes,
   input  logic [bba_pkg::ADDR_W-1:0]    req_release_address,
   input  logic [bba_pkg::ADDR_W-1:0]    pool_base,
   output logic                          busy,
   output bba_pkg::rsp_type              rsp,
   output logic [bba_pkg::USED_W-1:0]    bytes_in_use,
   output logic                          ram_wr_en,
   output logic [bba_pkg::IDX_W-1:0]     ram_wr_addr,
   output logic [bba_pkg::TAG_BITS-1:0]  ram_wr_data,
   output logic [bba_pkg::IDX_W-1:0]     ram_rd_addr,
   input  logic [bba_pkg::TAG_BITS-1:0]  ram_rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_TAG,
      ST_LEFT,
      ST_RIGHT
   } state_type;

   localparam logic [bba_pkg::IDX_W-1:0] LAST_IDX = bba_pkg::IDX_W'(bba_pkg::NUM_BLOCKS - 1);

   state_type                         state_ff, state_in;
   logic [bba_pkg::NUM_BLOCKS-1:0]    free_map_ff, free_map_in;
   logic [bba_pkg::IDX_W-1:0]         ptr_ff, ptr_in;
   logic [bba_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [bba_pkg::IDX_W-1:0]         start_ff, start_in;
   logic [bba_pkg::CNT_W-1:0]         run_ff, run_in;
   logic [bba_pkg::CNT_W-1:0]         need_ff, need_in;
   logic [bba_pkg::CNT_W-1:0]         busy_count_ff, busy_count_in;
   logic [bba_pkg::TAG_BITS-1:0]      next_tag_ff, next_tag_in;
   logic [bba_pkg::TAG_BITS-1:0]      tag_ff, tag_in;
   bba_pkg::rsp_type                  rsp_ff, rsp_in;

   logic [bba_pkg::ADDR_W-1:0]        offset;
   logic [bba_pkg::IDX_W-1:0]         req_idx;
   logic [bba_pkg::NEED_W-1:0]        need_full;
   logic [bba_pkg::CNT_W-1:0]         run_next;
   logic                              tag_match;
   logic [bba_pkg::CNT_W+bba_pkg::BLOCK_SHIFT-1:0] used_bytes;

   assign offset    = req_release_address - pool_base;
   assign req_idx   = bba_pkg::IDX_W'(offset >> bba_pkg::BLOCK_SHIFT);
   assign need_full = bba_pkg::NEED_W'(req_request_bytes >> bba_pkg::BLOCK_SHIFT)
                      + bba_pkg::NEED_W'(1);
   assign run_next  = run_ff + bba_pkg::CNT_W'(1);
   assign tag_match = !free_map_ff[ptr_ff] && (ram_rd_data == tag_ff);

   always_comb begin
      state_in      = state_ff;
      free_map_in   = free_map_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      start_in      = start_ff;
      run_in        = run_ff;
      need_in       = need_ff;
      busy_count_in = busy_count_ff;
      next_tag_in   = next_tag_ff;
      tag_in        = tag_ff;
      rsp_in        = rsp_ff;
      rsp_in.strobe = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_func)
                  bba_pkg::FUNC_ALLOC: begin
                     if (32'(need_full) > 32'(bba_pkg::NUM_BLOCKS)) begin
                        rsp_in.strobe        = 1'b1;
                        rsp_in.status        = bba_pkg::STATUS_NO_SPACE;
                        rsp_in.grant_address = '0;
                     end else begin
                        need_in  = bba_pkg::CNT_W'(need_full);
                        ptr_in   = '0;
                        run_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  bba_pkg::FUNC_FREE: begin
                     if ({1'b0, offset} >= bba_pkg::POOL_BYTES) begin
                        rsp_in.strobe        = 1'b1;
                        rsp_in.status        = bba_pkg::STATUS_BAD_ADDR;
                        rsp_in.grant_address = '0;
                     end else if (free_map_ff[req_idx]) begin
                        rsp_in.strobe        = 1'b1;
                        rsp_in.status        = bba_pkg::STATUS_OK;
                        rsp_in.grant_address = '0;
                     end else begin
                        // tag RAM read of the hit block issues now
                        ptr_in   = req_idx;
                        idx_in   = req_idx;
                        state_in = ST_TAG;
                     end
                  end
                  default: begin
                     rsp_in.strobe        = 1'b1;
                     rsp_in.status        = bba_pkg::STATUS_OK;
                     rsp_in.grant_address = '0;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (free_map_ff[ptr_ff] && (run_next == need_ff)) begin
               start_in    = bba_pkg::IDX_W'(bba_pkg::CNT_W'(ptr_ff) + bba_pkg::CNT_W'(1)
                                             - need_ff);
               ptr_in      = bba_pkg::IDX_W'(bba_pkg::CNT_W'(ptr_ff) + bba_pkg::CNT_W'(1)
                                             - need_ff);
               run_in      = need_ff;
               next_tag_in = next_tag_ff + bba_pkg::TAG_BITS'(1);
               state_in    = ST_MARK;
            end else if (ptr_ff == LAST_IDX) begin
               rsp_in.strobe        = 1'b1;
               rsp_in.status        = bba_pkg::STATUS_NO_SPACE;
               rsp_in.grant_address = '0;
               state_in             = ST_IDLE;
            end else begin
               run_in = free_map_ff[ptr_ff] ? run_next : '0;
               ptr_in = ptr_ff + bba_pkg::IDX_W'(1);
            end
         end

         ST_MARK: begin
            free_map_in[ptr_ff] = 1'b0;
            busy_count_in       = busy_count_ff + bba_pkg::CNT_W'(1);
            if (run_ff == bba_pkg::CNT_W'(1)) begin
               rsp_in.strobe        = 1'b1;
               rsp_in.status        = bba_pkg::STATUS_OK;
               rsp_in.grant_address = pool_base
                  + (bba_pkg::ADDR_W'(start_ff) << bba_pkg::BLOCK_SHIFT);
               state_in             = ST_IDLE;
            end else begin
               run_in = run_ff - bba_pkg::CNT_W'(1);
               ptr_in = ptr_ff + bba_pkg::IDX_W'(1);
            end
         end

         ST_TAG: begin
            tag_in              = ram_rd_data;
            free_map_in[idx_ff] = 1'b1;
            if (busy_count_ff != '0) begin
               busy_count_in = busy_count_ff - bba_pkg::CNT_W'(1);
            end
            if (idx_ff != '0) begin
               ptr_in   = idx_ff - bba_pkg::IDX_W'(1);
               state_in = ST_LEFT;
            end else if (idx_ff != LAST_IDX) begin
               ptr_in   = idx_ff + bba_pkg::IDX_W'(1);
               state_in = ST_RIGHT;
            end else begin
               rsp_in.strobe        = 1'b1;
               rsp_in.status        = bba_pkg::STATUS_OK;
               rsp_in.grant_address = '0;
               state_in             = ST_IDLE;
            end
         end

         ST_LEFT: begin
            if (tag_match) begin
               free_map_in[ptr_ff] = 1'b1;
               if (busy_count_ff != '0) begin
                  busy_count_in = busy_count_ff - bba_pkg::CNT_W'(1);
               end
            end
            if (tag_match && (ptr_ff != '0)) begin
               ptr_in = ptr_ff - bba_pkg::IDX_W'(1);
            end else if (idx_ff != LAST_IDX) begin
               ptr_in   = idx_ff + bba_pkg::IDX_W'(1);
               state_in = ST_RIGHT;
            end else begin
               rsp_in.strobe        = 1'b1;
               rsp_in.status        = bba_pkg::STATUS_OK;
               rsp_in.grant_address = '0;
               state_in             = ST_IDLE;
            end
         end

         ST_RIGHT: begin
            if (tag_match) begin
               free_map_in[ptr_ff] = 1'b1;
               if (busy_count_ff != '0) begin
                  busy_count_in = busy_count_ff - bba_pkg::CNT_W'(1);
               end
            end
            if (tag_match && (ptr_ff != LAST_IDX)) begin
               ptr_in = ptr_ff + bba_pkg::IDX_W'(1);
            end else begin
               rsp_in.strobe        = 1'b1;
               rsp_in.status        = bba_pkg::STATUS_OK;
               rsp_in.grant_address = '0;
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_map_ff   <= '1;
         busy_count_ff <= '0;
         next_tag_ff   <= '0;
         rsp_ff.strobe <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_map_ff   <= free_map_in;
         busy_count_ff <= busy_count_in;
         next_tag_ff   <= next_tag_in;
         rsp_ff.strobe <= rsp_in.strobe;
      end
      rsp_ff.status        <= rsp_in.status;
      rsp_ff.grant_address <= rsp_in.grant_address;
      ptr_ff               <= ptr_in;
      idx_ff               <= idx_in;
      start_ff             <= start_in;
      run_ff               <= run_in;
      need_ff              <= need_in;
      tag_ff               <= tag_in;
   end

   // read data always belongs to ptr_ff
   assign ram_rd_addr = ptr_in;
   assign ram_wr_en   = (state_ff == ST_MARK);
   assign ram_wr_addr = ptr_ff;
   assign ram_wr_data = next_tag_ff;

   assign busy         = (state_ff != ST_IDLE);
   assign rsp          = rsp_ff;
   assign used_bytes   = {busy_count_ff, {bba_pkg::BLOCK_SHIFT{1'b0}}};
   assign bytes_in_use = bba_pkg::USED_W'(used_bytes);

   busy_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      busy_count_ff == bba_pkg::CNT_W'($countones(~free_map_ff)))
      else $error("busy count out of step with free map");

   mark_hits_free_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> free_map_ff[ptr_ff])
      else $error("marking a block that is already busy");

   walk_after_release: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_LEFT) || (state_ff == ST_RIGHT)) |-> free_map_ff[idx_ff])
      else $error("release walk without the hit block released");

   strobe_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.strobe |-> (state_ff == ST_IDLE))
      else $error("result strobe while still working");

   failed_grant_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.strobe && (rsp_ff.status != bba_pkg::STATUS_OK)) |-> (rsp_ff.grant_address == '0))
      else $error("grant address set on a failed request");

endmodule
